// ===== rtl/tpe_pkg.sv =====
// tpe_pkg: shared constants, types and the arctangent table of the turtle position engine
// used by tpe_cordic, tpe_hmod and turtle_position_engine; no dependencies
package tpe_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int ATAN_IW          = 5;
  localparam int ATAN_W           = 30;

  // cordic x, y and angle registers
  localparam int ANG_W = 33;

  localparam int POS_W  = 32;
  localparam int HEAD_W = 25;

  localparam logic [HEAD_W-1:0] HEAD_MOD     = HEAD_W'(360 << FRAC_BITS);
  localparam logic [HEAD_W-1:0] HALF_TURN    = HEAD_W'(180 << FRAC_BITS);
  localparam logic [HEAD_W-1:0] QUARTER_TURN = HEAD_W'(90 << FRAC_BITS);

  // heading remainder unit: restoring subtraction of HEAD_MOD << k, k from MOD_STEPS-1 down
  localparam int MOD_STEPS = 8;
  localparam int MOD_K_W   = $clog2(MOD_STEPS);
  localparam int MOD_W     = 34;
  localparam logic [MOD_W-1:0] MOD_OFFSET = MOD_W'(HEAD_MOD) << (MOD_STEPS - 1);

  localparam logic signed [ANG_W-1:0] GAIN_Q30       = 33'sh026DD3B6A;
  localparam logic signed [31:0]      DEG_TO_RAD_Q30 = 32'sd18740330;

  typedef enum logic [1:0] {
    REQ_ADVANCE = 2'd0,
    REQ_LEFT    = 2'd1,
    REQ_RIGHT   = 2'd2,
    REQ_GOTO    = 2'd3
  } req_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic [ATAN_W-1:0] atan_q30(input logic [ATAN_IW-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 30'h3243F6A8;
      5'd1:    v = 30'h1DAC6705;
      5'd2:    v = 30'h0FADBAFC;
      5'd3:    v = 30'h07F56EA6;
      5'd4:    v = 30'h03FEAB76;
      5'd5:    v = 30'h01FFD55B;
      5'd6:    v = 30'h00FFFAAA;
      5'd7:    v = 30'h007FFF55;
      5'd8:    v = 30'h003FFFEA;
      5'd9:    v = 30'h001FFFFD;
      5'd10:   v = 30'h000FFFFF;
      5'd11:   v = 30'h0007FFFF;
      5'd12:   v = 30'h0003FFFF;
      5'd13:   v = 30'h0001FFFF;
      5'd14:   v = 30'h0000FFFF;
      5'd15:   v = 30'h00007FFF;
      5'd16:   v = 30'h00003FFF;
      5'd17:   v = 30'h00001FFF;
      5'd18:   v = 30'h00000FFF;
      5'd19:   v = 30'h000007FF;
      5'd20:   v = 30'h000003FF;
      5'd21:   v = 30'h000001FF;
      5'd22:   v = 30'h000000FF;
      5'd23:   v = 30'h0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/tpe_cordic.sv =====
// tpe_cordic: iterative rotation-mode cordic, one micro-rotation per cycle
// depends on tpe_pkg for widths, gain and the arctangent table
module tpe_cordic import tpe_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [ANG_W-1:0] z0_i,
  output unit_stat_t              stat_o,
  output logic signed [ANG_W-1:0] cos_o,
  output logic signed [ANG_W-1:0] sin_o
);

  localparam int NSTEP = (STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : STEPS;
  localparam int CNT_W = $clog2(NSTEP);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NSTEP - 1);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [ANG_W-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [ANG_W-1:0] xs, ys, at;

  assign xs = x_q >>> cnt_q;
  assign ys = y_q >>> cnt_q;
  assign at = $signed({{(ANG_W-ATAN_W){1'b0}}, atan_q30(ATAN_IW'(cnt_q))});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      x_d    = GAIN_Q30;
      y_d    = '0;
      z_d    = z0_i;
    end else if (busy_q) begin
      if (!z_q[ANG_W-1]) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        cnt_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign cos_o       = x_q;
  assign sin_o       = y_q;

endmodule

// ===== rtl/tpe_hmod.sv =====
// tpe_hmod: iterative remainder of an offset heading sum modulo 360 degrees
// depends on tpe_pkg for the modulus, the offset width and the step count
module tpe_hmod import tpe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MOD_W-1:0]  value_i,
  output unit_stat_t        stat_o,
  output logic [HEAD_W-1:0] heading_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [MOD_K_W-1:0] k_q, k_d;
  logic [MOD_W-1:0]   rem_q, rem_d;
  logic [MOD_W-1:0]   trial;

  assign trial = MOD_W'(HEAD_MOD) << k_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    k_d    = k_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      k_d    = MOD_K_W'(MOD_STEPS - 1);
      rem_d  = value_i;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
      end
      k_d = k_q - 1'b1;
      if (k_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign heading_o   = rem_q[HEAD_W-1:0];

endmodule

// ===== rtl/turtle_position_engine.sv =====
// Turtle position engine: keeps a Q16.16 position and a Q9.16 heading in degrees and returns
// the updated state for every request. One request is worked at a time. An advance makes one pass
// through the single 32 x 32 multiplier for the angle, runs the iterative cordic with one
// micro-rotation per cycle, then makes two more multiplier passes for the deltas; a turn waits on
// the eight-step remainder unit; a go-to loads the target directly. The next request is taken in
// the cycle after the result register is loaded, also while that result still waits on the output.
// depends on tpe_pkg, tpe_cordic and tpe_hmod
module turtle_position_engine import tpe_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // step_value, target_x, target_y
  input  logic [1:0]  s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata   // pos_x, pos_y, heading_deg, zero pad
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FOLD = 4'd1;
  localparam logic [3:0] S_ZMUL = 4'd2;
  localparam logic [3:0] S_ROTS = 4'd3;
  localparam logic [3:0] S_ROT  = 4'd4;
  localparam logic [3:0] S_MULX = 4'd5;
  localparam logic [3:0] S_MULY = 4'd6;
  localparam logic [3:0] S_ADDY = 4'd7;
  localparam logic [3:0] S_HMOD = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]               state_q, state_d;
  logic signed [POS_W-1:0]  x_q, x_d, y_q, y_d;
  logic [HEAD_W-1:0]        head_q, head_d;
  logic signed [POS_W-1:0]  val_q, val_d;
  logic signed [HEAD_W:0]   d_q, d_d;
  logic                     neg_q, neg_d;
  logic signed [63:0]       prod_q, prod_d;
  logic                     m_valid_q, m_valid_d;
  logic [95:0]              m_data_q, m_data_d;

  req_e                     req;
  logic signed [POS_W-1:0]  step_value, target_x, target_y;
  logic signed [31:0]       mul_a, mul_b;
  logic signed [63:0]       mul_p;
  logic signed [HEAD_W:0]   h_s, d_wrap;
  logic signed [31:0]       c_trig, s_trig;
  logic [MOD_W-1:0]         turn_sum;
  logic                     cordic_start, hmod_start;
  logic signed [ANG_W-1:0]  cos_w, sin_w;
  logic [HEAD_W-1:0]        hmod_res;
  unit_stat_t               cordic_stat, hmod_stat;

  assign req        = req_e'(s_axis_tuser);
  assign step_value = s_axis_tdata[31:0];
  assign target_x   = s_axis_tdata[63:32];
  assign target_y   = s_axis_tdata[95:64];

  function automatic logic signed [POS_W-1:0] add_sat(input logic signed [POS_W-1:0] cur,
                                                      input logic signed [63:0] p);
    logic signed [63:0] rnd;
    logic signed [33:0] dlt;
    logic signed [34:0] sum;
    logic signed [POS_W-1:0] r;
    rnd = p + 64'sd536870912;
    dlt = rnd[63:30];
    sum = 35'(cur) + 35'(dlt);
    if (sum > 35'sd2147483647) begin
      r = {1'b0, {(POS_W-1){1'b1}}};
    end else if (sum < -35'sd2147483648) begin
      r = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      r = sum[POS_W-1:0];
    end
    return r;
  endfunction

  // shared multiplier
  assign mul_a = (state_q == S_ZMUL) ? 32'(d_q) : val_q;
  assign mul_b = (state_q == S_ZMUL) ? DEG_TO_RAD_Q30 :
                 (state_q == S_MULX) ? c_trig : s_trig;
  assign mul_p = mul_a * mul_b;

  assign c_trig = neg_q ? 32'(-cos_w) : 32'(cos_w);
  assign s_trig = neg_q ? 32'(-sin_w) : 32'(sin_w);

  assign h_s    = $signed({1'b0, head_q});
  assign d_wrap = (head_q >= HALF_TURN) ? h_s - $signed({1'b0, HEAD_MOD}) : h_s;

  assign turn_sum = (req == REQ_LEFT) ?
                    MOD_W'(head_q) + MOD_W'(step_value) + MOD_OFFSET :
                    MOD_W'(head_q) - MOD_W'(step_value) + MOD_OFFSET;

  always_comb begin
    state_d      = state_q;
    x_d          = x_q;
    y_d          = y_q;
    head_d       = head_q;
    val_d        = val_q;
    d_d          = d_q;
    neg_d        = neg_q;
    prod_d       = prod_q;
    m_valid_d    = m_valid_q;
    m_data_d     = m_data_q;
    cordic_start = 1'b0;
    hmod_start   = 1'b0;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          val_d = step_value;
          case (req)
            REQ_ADVANCE: state_d = S_FOLD;
            REQ_LEFT, REQ_RIGHT: begin
              hmod_start = 1'b1;
              state_d    = S_HMOD;
            end
            default: begin
              x_d     = target_x;
              y_d     = target_y;
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_FOLD: begin
        neg_d = 1'b0;
        d_d   = d_wrap;
        if (d_wrap > $signed({1'b0, QUARTER_TURN})) begin
          d_d   = d_wrap - $signed({1'b0, HALF_TURN});
          neg_d = 1'b1;
        end else if (d_wrap < -$signed({1'b0, QUARTER_TURN})) begin
          d_d   = d_wrap + $signed({1'b0, HALF_TURN});
          neg_d = 1'b1;
        end
        state_d = S_ZMUL;
      end
      S_ZMUL: begin
        prod_d  = mul_p;
        state_d = S_ROTS;
      end
      S_ROTS: begin
        cordic_start = 1'b1;
        state_d      = S_ROT;
      end
      S_ROT: begin
        if (cordic_stat.done) begin
          state_d = S_MULX;
        end
      end
      S_MULX: begin
        prod_d  = mul_p;
        state_d = S_MULY;
      end
      S_MULY: begin
        prod_d  = mul_p;
        x_d     = add_sat(x_q, prod_q);
        state_d = S_ADDY;
      end
      S_ADDY: begin
        y_d     = add_sat(y_q, prod_q);
        state_d = S_FIN;
      end
      S_HMOD: begin
        if (hmod_stat.done) begin
          head_d  = hmod_res;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {7'd0, head_q, y_q, x_q};
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      x_q       <= '0;
      y_q       <= '0;
      head_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      x_q       <= x_d;
      y_q       <= y_d;
      head_q    <= head_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    d_q      <= d_d;
    neg_q    <= neg_d;
    prod_q   <= prod_d;
    m_data_q <= m_data_d;
  end

  tpe_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .z0_i    (prod_q[FRAC_BITS +: ANG_W]),
    .stat_o  (cordic_stat),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  tpe_hmod u_hmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (hmod_start),
    .value_i   (turn_sum),
    .stat_o    (hmod_stat),
    .heading_o (hmod_res)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q < HEAD_MOD)
    else $error("heading left the range of one turn");

  a_cordic_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cordic_stat.busy |-> state_q == S_ROT)
    else $error("cordic running outside the rotation state");

  a_hmod_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hmod_stat.busy |-> state_q == S_HMOD)
    else $error("remainder unit running outside its state");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && (!m_valid_q || m_axis_tready)) |=> m_axis_tvalid)
    else $error("finished request did not reach the output");

endmodule

// ===== verif/tb_turtle_position_engine.sv =====
// self-checking testbench for turtle_position_engine: a directed table, then random requests
// checked against a cycle-free predictor of position and heading; needs tpe_pkg and the rtl
`timescale 1ns / 100ps

module tb_turtle_position_engine;
  import tpe_pkg::*;

  localparam int     TRIG_ITERS     = (CORDIC_STEPS_DEF > 24) ? 24 : CORDIC_STEPS_DEF;
  localparam int     RANDOM_ITEMS   = 1850;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     DRAIN_CYCLES   = 40;
  localparam int     SQUEEZE_AFTER  = 300;
  localparam int     SQUEEZE_LEN    = 600;
  localparam longint TURN_L         = longint'(HEAD_MOD);
  localparam longint HALF_L         = longint'(HALF_TURN);
  localparam longint QUARTER_L      = longint'(QUARTER_TURN);
  localparam longint ROUND_HALF     = 64'sd536870912;
  localparam longint POS_MAX        = 64'sd2147483647;
  localparam longint POS_MIN        = -64'sd2147483648;

  localparam longint ARCTAN_Q30 [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  typedef struct packed {
    req_e        kind;
    logic [31:0] step;
    logic [31:0] tx;
    logic [31:0] ty;
  } turtle_cmd_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [24:0] heading;
  } turtle_pose_t;

  typedef struct {
    turtle_cmd_t  cmd;
    bit           typed;
    turtle_pose_t pose;
  } plan_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;

  turtle_pose_t model_pose;
  turtle_pose_t pose_q[$];
  plan_row_t    plan_q[$];
  int           fail_count;
  int           idle_cycles;

  turtle_position_engine u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void heading_trig(input logic [24:0] head, output longint cos_q30,
                                       output longint sin_q30);
    longint ang, cx, cy, nx, z;
    bit     flip;
    ang  = longint'(head);
    flip = 1'b0;
    cx   = longint'(GAIN_Q30);
    cy   = 0;
    if (ang >= HALF_L) ang -= TURN_L;
    // fold into the right half plane, negate afterwards
    if (ang > QUARTER_L) begin
      ang -= HALF_L;
      flip = 1'b1;
    end else if (ang < -QUARTER_L) begin
      ang += HALF_L;
      flip = 1'b1;
    end
    z = (ang * longint'(DEG_TO_RAD_Q30)) >>> FRAC_BITS;
    for (int i = 0; i < TRIG_ITERS; i++) begin
      if (z >= 0) begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        z  = z - ARCTAN_Q30[i];
      end else begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        z  = z + ARCTAN_Q30[i];
      end
      cx = nx;
    end
    cos_q30 = flip ? -cx : cx;
    sin_q30 = flip ? -cy : cy;
  endfunction

  function automatic logic [31:0] clamp_pos(input longint v);
    if (v > POS_MAX) return 32'h7FFFFFFF;
    if (v < POS_MIN) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic turtle_pose_t turtle_next_pose(input turtle_pose_t p, input turtle_cmd_t c);
    turtle_pose_t n;
    longint       v, cs, sn, r;
    n = p;
    v = longint'($signed(c.step));
    case (c.kind)
      REQ_ADVANCE: begin
        heading_trig(p.heading, cs, sn);
        n.x = clamp_pos(longint'($signed(p.x)) + ((v * cs + ROUND_HALF) >>> 30));
        n.y = clamp_pos(longint'($signed(p.y)) + ((v * sn + ROUND_HALF) >>> 30));
      end
      REQ_LEFT, REQ_RIGHT: begin
        r = (c.kind == REQ_LEFT) ? longint'(p.heading) + v : longint'(p.heading) - v;
        r = r % TURN_L;
        if (r < 0) r += TURN_L;
        n.heading = r[24:0];
      end
      default: begin
        n.x = c.tx;
        n.y = c.ty;
      end
    endcase
    return n;
  endfunction

  function automatic logic [31:0] extreme_word(input int k);
    case (k)
      0:       return 32'h7FFFFFFF;
      1:       return 32'h80000000;
      2:       return 32'h00000000;
      default: return 32'hFFFFFFFF;
    endcase
  endfunction

  function automatic turtle_cmd_t random_cmd();
    turtle_cmd_t c;
    int          pick;
    c.step = $urandom;
    c.tx   = $urandom;
    c.ty   = $urandom;
    pick   = $urandom_range(0, 99);
    if (pick < 45) begin
      c.kind = REQ_ADVANCE;
      if ($urandom_range(0, 9) != 0) c.step = 32'($signed(c.step) >>> $urandom_range(6, 20));
    end else if (pick < 85) begin
      c.kind = (pick < 65) ? REQ_LEFT : REQ_RIGHT;
      case ($urandom_range(0, 6))
        0: c.step = c.step;
        1: c.step = 32'((int'($urandom_range(0, 16)) - 8) * 32'sh005A0000);
        2: c.step = 32'(int'($urandom_range(0, 2)) - 1);
        default: c.step = 32'($signed(c.step) >>> $urandom_range(6, 12));
      endcase
    end else begin
      c.kind = REQ_GOTO;
      if ($urandom_range(0, 9) == 0) begin
        c.tx = extreme_word($urandom_range(0, 3));
        c.ty = extreme_word($urandom_range(0, 3));
      end else begin
        c.tx = 32'($signed(c.tx) >>> $urandom_range(0, 12));
        c.ty = 32'($signed(c.ty) >>> $urandom_range(0, 12));
      end
    end
    return c;
  endfunction

  task automatic add_row(input req_e kind, input logic [31:0] step, input logic [31:0] tx,
                         input logic [31:0] ty, input bit typed, input logic [31:0] x,
                         input logic [31:0] y, input logic [24:0] h);
    plan_row_t row;
    row.cmd.kind     = kind;
    row.cmd.step     = step;
    row.cmd.tx       = tx;
    row.cmd.ty       = ty;
    row.typed        = typed;
    row.pose.x       = x;
    row.pose.y       = y;
    row.pose.heading = h;
    plan_q.push_back(row);
  endtask

  task automatic issue_cmd(input turtle_cmd_t c, input bit typed, input turtle_pose_t typed_pose,
                           input bit no_idle);
    int           gap;
    turtle_pose_t nxt;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.kind;
    s_axis_tdata  <= {c.ty, c.tx, c.step};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    nxt        = turtle_next_pose(model_pose, c);
    model_pose = nxt;
    pose_q.push_back(typed ? typed_pose : nxt);
  endtask

  task automatic compare_pose(input turtle_pose_t want, input logic [95:0] got);
    if (got[31:0] !== want.x || got[63:32] !== want.y || got[88:64] !== want.heading ||
        got[95:89] !== 7'd0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch: exp x=%h y=%h h=%h  got x=%h y=%h h=%h pad=%h",
                 want.x, want.y, want.heading, got[31:0], got[63:32], got[88:64], got[95:89]);
    end
  endtask

  // result side: random back-pressure, one long hold-off to fill the engine
  initial begin : rx_side
    int           stall_left;
    int           seen;
    bit           squeezed;
    turtle_pose_t want;
    stall_left    = 0;
    seen          = 0;
    squeezed      = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        seen++;
        if (pose_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          want = pose_q.pop_front();
          compare_pose(want, m_axis_tdata);
        end
      end
      if (!squeezed && seen >= SQUEEZE_AFTER) begin
        squeezed   = 1'b1;
        stall_left = SQUEEZE_LEN;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (((seen / 250) % 4) != 3) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[turtle_position_engine] ERROR");
      $finish;
    end
  end

  initial begin : tx_side
    turtle_pose_t blank;
    blank         = '0;
    model_pose    = '0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_ADVANCE;

    add_row(REQ_ADVANCE, 32'h0, 32'h0, 32'h0, 1, 32'h0, 32'h0, 25'h0);
    add_row(REQ_GOTO, 32'hDEADBEEF, 32'h7FFFFFFF, 32'h80000000, 1,
            32'h7FFFFFFF, 32'h80000000, 25'h0);
    add_row(REQ_LEFT, 32'h005A0000, 32'hFFFFFFFF, 32'h0, 1, 32'h7FFFFFFF, 32'h80000000,
            25'h05A0000);
    add_row(REQ_ADVANCE, 32'h7FFFFFFF, 32'h0, 32'h0, 0, 32'h0, 32'h0, 25'h0);
    add_row(REQ_GOTO, 32'h0, 32'h0, 32'h0, 1, 32'h0, 32'h0, 25'h05A0000);
    // one step below zero wraps to just under a full turn
    add_row(REQ_RIGHT, 32'h005A0001, 32'h0, 32'h0, 1, 32'h0, 32'h0, 25'h167FFFF);
    add_row(REQ_LEFT, 32'h00000001, 32'h0, 32'h0, 1, 32'h0, 32'h0, 25'h0);
    add_row(REQ_GOTO, 32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 32'h7FFFFFFF, 32'h7FFFFFFF, 25'h0);
    add_row(REQ_ADVANCE, 32'h7FFFFFFF, 32'h0, 32'h0, 0, 32'h0, 32'h0, 25'h0);
    add_row(REQ_GOTO, 32'h0, 32'h80000000, 32'h80000000, 1, 32'h80000000, 32'h80000000, 25'h0);
    add_row(REQ_LEFT, 32'h00B40000, 32'h0, 32'h0, 1, 32'h80000000, 32'h80000000, 25'h0B40000);
    add_row(REQ_ADVANCE, 32'h7FFFFFFF, 32'h0, 32'h0, 0, 32'h0, 32'h0, 25'h0);
    add_row(REQ_ADVANCE, 32'h80000000, 32'h0, 32'h0, 0, 32'h0, 32'h0, 25'h0);
    add_row(REQ_GOTO, 32'h0, 32'h0, 32'h0, 1, 32'h0, 32'h0, 25'h0B40000);
    add_row(REQ_LEFT, 32'h005A0000, 32'h0, 32'h0, 1, 32'h0, 32'h0, 25'h10E0000);
    add_row(REQ_ADVANCE, 32'h00010000, 32'h0, 32'h0, 0, 32'h0, 32'h0, 25'h0);
    add_row(REQ_RIGHT, 32'h80000000, 32'h0, 32'h0, 0, 32'h0, 32'h0, 25'h0);
    add_row(REQ_ADVANCE, 32'h00640000, 32'h0, 32'h0, 0, 32'h0, 32'h0, 25'h0);
    add_row(REQ_LEFT, 32'h7FFFFFFF, 32'h0, 32'h0, 0, 32'h0, 32'h0, 25'h0);
    add_row(REQ_RIGHT, 32'hFFFFFFFF, 32'h0, 32'h0, 0, 32'h0, 32'h0, 25'h0);
    add_row(REQ_ADVANCE, 32'hFFFF0000, 32'h0, 32'h0, 0, 32'h0, 32'h0, 25'h0);
    add_row(REQ_GOTO, 32'h0, 32'h12345678, 32'hEDCBA988, 0, 32'h0, 32'h0, 25'h0);
    add_row(REQ_LEFT, 32'h005A0001, 32'h0, 32'h0, 0, 32'h0, 32'h0, 25'h0);
    add_row(REQ_ADVANCE, 32'h01000000, 32'h0, 32'h0, 0, 32'h0, 32'h0, 25'h0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_q[i]) issue_cmd(plan_q[i].cmd, plan_q[i].typed, plan_q[i].pose, 1'b0);
    for (int n = 0; n < RANDOM_ITEMS; n++)
      issue_cmd(random_cmd(), 1'b0, blank, ((n / 200) % 4) == 1);
    s_axis_tvalid <= 1'b0;

    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pose_q.size() == 0) begin
      $display("[turtle_position_engine] OK");
    end else begin
      $display("[turtle_position_engine] ERROR");
    end
    $finish;
  end

endmodule
